// ----- hdl/dsf_pkg.sv -----
// shared types, constants and fixed-point helpers of the damped spring follower
package dsf_pkg;

    // position saturation width, capped at the output field width
    localparam int POS_WIDTH = 32;
    localparam int POS_W_EFF = (POS_WIDTH > 32) ? 32 : POS_WIDTH;
    localparam logic signed [63:0] POS_HI = (64'sd1 <<< (POS_W_EFF - 1)) - 64'sd1;
    localparam logic signed [63:0] POS_LO = -POS_HI - 64'sd1;

    localparam logic signed [63:0] S32_HI = 64'sd2147483647;
    localparam logic signed [63:0] S32_LO = -64'sd2147483648;

    localparam int STEPS_DEFAULT = 30;
    localparam int STEPS_MAX     = 200;
    localparam logic [31:0] MIN_LENGTH = 32'd7;
    localparam logic signed [48:0] RESET_LIMIT = 49'sd1310720;
    localparam logic signed [50:0] BL_MAX = 51'sd281474976710655;
    localparam logic signed [50:0] BL_MIN = -51'sd281474976710656;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_STIFFNESS   = 3'd0,
        CFG_DAMPING     = 3'd1,
        CFG_FRICTION    = 3'd2,
        CFG_REST_LENGTH = 3'd3,
        CFG_MASS        = 3'd4,
        CFG_STEPS       = 3'd5,
        CFG_ZERO_FRAME  = 3'd6,
        CFG_TIME_SOURCE = 3'd7
    } cfg_index_t;

    typedef enum logic [3:0] {
        LOP_IDLE,
        LOP_SNAP,
        LOP_DIFF,
        LOP_SQ,
        LOP_DOT,
        LOP_DIR_DIV,
        LOP_ACC,
        LOP_F_DIV,
        LOP_FR,
        LOP_VEL,
        LOP_PMUL,
        LOP_POS
    } lane_op_t;

    typedef enum logic [2:0] {
        MOP_IDLE,
        MOP_SUM,
        MOP_SQRT,
        MOP_LEN,
        MOP_PROJ_DIV,
        MOP_SK,
        MOP_DP,
        MOP_VALUE
    } merge_op_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_BACKLOG,
        ST_DECIDE,
        ST_CHECK,
        ST_DIFF,
        ST_SQ,
        ST_DOT,
        ST_SUM,
        ST_SQRT,
        ST_SQRT_WAIT,
        ST_LEN,
        ST_DIV1,
        ST_DIV1_WAIT,
        ST_SK,
        ST_DP,
        ST_VALUE,
        ST_ACC,
        ST_FDIV,
        ST_FR,
        ST_FDIV_WAIT,
        ST_VEL,
        ST_PMUL,
        ST_POS,
        ST_OUT
    } state_t;

    typedef struct packed {
        lane_op_t op;
    } lane_ctl_t;

    typedef struct packed {
        merge_op_t op;
    } merge_ctl_t;

    typedef struct packed {
        logic sqrt_busy;
        logic div_busy;
    } merge_stat_t;

    // sign extension of a 32-bit value
    function automatic logic signed [63:0] sx64(input logic signed [31:0] x);
        return {{32{x[31]}}, x};
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [63:0] r;
        r = (v < S32_LO) ? S32_LO : ((v > S32_HI) ? S32_HI : v);
        return r[31:0];
    endfunction

    function automatic logic signed [31:0] sat_pos(input logic signed [63:0] v);
        logic signed [63:0] r;
        r = (v < POS_LO) ? POS_LO : ((v > POS_HI) ? POS_HI : v);
        return r[31:0];
    endfunction

    // q16.16 product rounded half away from zero
    function automatic logic signed [63:0] qmul(input logic signed [32:0] a,
                                                input logic signed [32:0] b);
        logic        neg;
        logic [32:0] ma;
        logic [32:0] mb;
        logic [65:0] prod;
        logic [49:0] r;
        neg  = a[32] ^ b[32];
        ma   = a[32] ? 33'(-a) : 33'(a);
        mb   = b[32] ? 33'(-b) : 33'(b);
        prod = {33'b0, ma} * {33'b0, mb};
        prod = prod + 66'd32768;
        r    = prod[65:16];
        return neg ? -$signed({14'b0, r}) : $signed({14'b0, r});
    endfunction

endpackage

// ----- hdl/dsf_div.sv -----
// radix-2 restoring divider for rounded, saturated q16.16 quotients
module dsf_div (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               neg,
    input  logic [47:0]        mag,
    input  logic [31:0]        den,
    output logic               busy,
    output logic signed [31:0] quo
);

    logic        busy_reg, busy_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic [64:0] num_reg, num_next;
    logic [31:0] rem_reg, rem_next;
    logic [64:0] q_reg, q_next;
    logic        neg_reg, neg_next;
    logic [31:0] den_reg, den_next;
    logic [32:0] r2;
    logic        ge;
    logic [32:0] r2_sub;
    logic [32:0] q_sat;

    // one quotient bit per cycle
    always_comb
    begin
        r2        = {rem_reg, num_reg[64]};
        ge        = r2 >= {1'b0, den_reg};
        r2_sub    = r2 - {1'b0, den_reg};
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        neg_next  = neg_reg;
        den_next  = den_reg;
        if (start)
        begin
            num_next  = {1'b0, mag, 16'b0} + {34'b0, den[31:1]};
            rem_next  = '0;
            q_next    = '0;
            cnt_next  = 7'd64;
            busy_next = 1'b1;
            neg_next  = neg;
            den_next  = den;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? r2_sub[31:0] : r2[31:0];
            q_next   = {q_reg[63:0], ge};
            num_next = {num_reg[63:0], 1'b0};
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd0)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
        neg_reg <= neg_next;
        den_reg <= den_next;
    end

    // saturate the magnitude, then apply the sign
    always_comb
    begin
        if (!neg_reg && q_reg > 65'h7FFFFFFF)
        begin
            q_sat = 33'h07FFFFFFF;
        end
        else if (neg_reg && q_reg > 65'h80000000)
        begin
            q_sat = 33'h080000000;
        end
        else
        begin
            q_sat = q_reg[32:0];
        end
    end

    assign quo  = neg_reg ? 32'(-q_sat) : q_sat[31:0];
    assign busy = busy_reg;

endmodule

// ----- hdl/dsf_sqrt.sv -----
// bit-pair integer square root of a 64-bit value, one result bit per cycle
module dsf_sqrt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] val,
    output logic        busy,
    output logic [31:0] root
);

    logic        busy_reg, busy_next;
    logic [4:0]  k_reg, k_next;
    logic [63:0] v_reg, v_next;
    logic [63:0] res_reg, res_next;
    logic [63:0] bitv;
    logic [63:0] trial;

    always_comb
    begin
        bitv      = 64'd1 << {k_reg, 1'b0};
        trial     = res_reg + bitv;
        busy_next = busy_reg;
        k_next    = k_reg;
        v_next    = v_reg;
        res_next  = res_reg;
        if (start)
        begin
            busy_next = 1'b1;
            k_next    = 5'd31;
            v_next    = val;
            res_next  = '0;
        end
        else if (busy_reg)
        begin
            if (v_reg >= trial)
            begin
                v_next   = v_reg - trial;
                res_next = (res_reg >> 1) + bitv;
            end
            else
            begin
                res_next = res_reg >> 1;
            end
            k_next = k_reg - 5'd1;
            if (k_reg == 5'd0)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            k_reg    <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            k_reg    <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg   <= v_next;
        res_reg <= res_next;
    end

    assign busy = busy_reg;
    assign root = res_reg[31:0];

endmodule

// ----- hdl/dsf_lane.sv -----
// one axis of the follower: holds position and velocity, runs the per-axis substep
module dsf_lane (
    input  logic               clk,
    input  logic               rst_n,
    input  dsf_pkg::lane_ctl_t ctl,
    input  logic signed [31:0] tg,
    input  logic [31:0]        m,
    input  logic signed [31:0] value,
    input  logic [31:0]        friction,
    input  logic [31:0]        mass_eff,
    input  logic [16:0]        dt,
    output logic [63:0]        sq,
    output logic signed [49:0] dotp,
    output logic signed [31:0] pos,
    output logic               busy
);

    logic signed [31:0] pos_reg, pos_next;
    logic signed [31:0] vel_reg, vel_next;
    logic signed [31:0] d_reg;
    logic signed [31:0] vd_reg;
    logic [63:0]        sq_reg;
    logic signed [49:0] dot_reg;
    logic signed [31:0] acc_reg;
    logic signed [31:0] fr_reg;
    logic signed [31:0] pm_reg;
    logic signed [63:0] d_prod;
    logic signed [63:0] dot_full;
    logic signed [31:0] div_num;
    logic [31:0]        div_den;
    logic [31:0]        div_abs;
    logic               div_start;
    logic signed [31:0] quo;

    // divider operand select: direction first, then force over mass
    always_comb
    begin
        div_start = (ctl.op == dsf_pkg::LOP_DIR_DIV) || (ctl.op == dsf_pkg::LOP_F_DIV);
        div_num   = (ctl.op == dsf_pkg::LOP_F_DIV) ? acc_reg : d_reg;
        div_den   = (ctl.op == dsf_pkg::LOP_F_DIV) ? mass_eff : m;
        div_abs   = div_num[31] ? 32'(-div_num) : div_num;
    end

    dsf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .neg   (div_num[31]),
        .mag   ({16'b0, div_abs}),
        .den   (div_den),
        .busy  (busy),
        .quo   (quo)
    );

    assign d_prod   = d_reg * d_reg;
    assign dot_full = dsf_pkg::qmul({vd_reg[31], vd_reg}, {d_reg[31], d_reg});

    // state update of position and velocity
    always_comb
    begin
        pos_next = pos_reg;
        vel_next = vel_reg;
        case (ctl.op)
            dsf_pkg::LOP_SNAP:
            begin
                pos_next = dsf_pkg::sat_pos(dsf_pkg::sx64(tg));
                vel_next = '0;
            end
            dsf_pkg::LOP_VEL:
            begin
                vel_next = dsf_pkg::sat32(dsf_pkg::sx64(vel_reg) + dsf_pkg::sx64(quo)
                                          - dsf_pkg::sx64(fr_reg));
            end
            dsf_pkg::LOP_POS:
            begin
                pos_next = dsf_pkg::sat_pos(dsf_pkg::sx64(pos_reg) + dsf_pkg::sx64(pm_reg));
            end
            default:
            begin
                pos_next = pos_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            vel_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
            vel_reg <= vel_next;
        end
    end

    // intermediate terms of the substep
    always_ff @(posedge clk)
    begin
        case (ctl.op)
            dsf_pkg::LOP_DIFF:
            begin
                d_reg <= dsf_pkg::sat32(dsf_pkg::sx64(tg) - dsf_pkg::sx64(pos_reg));
            end
            dsf_pkg::LOP_SQ:
            begin
                sq_reg <= $unsigned(d_prod);
                vd_reg <= dsf_pkg::sat32(dsf_pkg::sx64(d_reg) - dsf_pkg::sx64(vel_reg));
            end
            dsf_pkg::LOP_DOT:
            begin
                dot_reg <= dot_full[49:0];
            end
            dsf_pkg::LOP_ACC:
            begin
                acc_reg <= dsf_pkg::sat32(dsf_pkg::qmul({value[31], value}, {quo[31], quo}));
            end
            dsf_pkg::LOP_FR:
            begin
                fr_reg <= dsf_pkg::sat32(dsf_pkg::qmul({1'b0, friction},
                                                       {vel_reg[31], vel_reg}));
            end
            dsf_pkg::LOP_PMUL:
            begin
                pm_reg <= dsf_pkg::sat32(dsf_pkg::qmul({vel_reg[31], vel_reg},
                                                       {16'b0, dt}));
            end
            default:
            begin
                d_reg <= d_reg;
            end
        endcase
    end

    assign sq   = sq_reg;
    assign dotp = dot_reg;
    assign pos  = pos_reg;

endmodule

// ----- hdl/dsf_merge.sv -----
// merging stage: length, projected speed and spring force from the three lanes
module dsf_merge (
    input  logic                 clk,
    input  logic                 rst_n,
    input  dsf_pkg::merge_ctl_t  ctl,
    input  logic [63:0]          sq [3],
    input  logic signed [49:0]   dotp [3],
    input  logic [31:0]          stiffness,
    input  logic [31:0]          damping,
    input  logic [31:0]          rest_length,
    output logic [31:0]          m,
    output logic signed [31:0]   value,
    output dsf_pkg::merge_stat_t stat
);

    logic [63:0]        sumsq_reg;
    logic signed [49:0] dotq_reg;
    logic [31:0]        m_reg;
    logic signed [31:0] stretch_reg;
    logic signed [31:0] sk_reg;
    logic signed [31:0] dp_reg;
    logic signed [31:0] value_reg;
    logic [31:0]        root;
    logic [31:0]        m_eff;
    logic [47:0]        dot_abs;
    logic signed [31:0] quo;
    logic               sqrt_busy;
    logic               div_busy;
    logic signed [49:0] dot_neg;

    dsf_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (ctl.op == dsf_pkg::MOP_SQRT),
        .val   (sumsq_reg),
        .busy  (sqrt_busy),
        .root  (root)
    );

    assign dot_neg = -dotq_reg;
    assign dot_abs = dotq_reg[49] ? dot_neg[47:0] : dotq_reg[47:0];

    dsf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (ctl.op == dsf_pkg::MOP_PROJ_DIV),
        .neg   (dotq_reg[49]),
        .mag   (dot_abs),
        .den   (m_reg),
        .busy  (div_busy),
        .quo   (quo)
    );

    // a zero length stands in as the minimum length
    assign m_eff = (root == 32'd0) ? dsf_pkg::MIN_LENGTH : root;

    always_ff @(posedge clk)
    begin
        case (ctl.op)
            dsf_pkg::MOP_SUM:
            begin
                sumsq_reg <= sq[0] + sq[1] + sq[2];
                dotq_reg  <= dotp[0] + dotp[1] + dotp[2];
            end
            dsf_pkg::MOP_LEN:
            begin
                m_reg       <= m_eff;
                stretch_reg <= dsf_pkg::sat32($signed({32'b0, m_eff})
                                              - $signed({32'b0, rest_length}));
            end
            dsf_pkg::MOP_SK:
            begin
                sk_reg <= dsf_pkg::sat32(dsf_pkg::qmul({1'b0, stiffness},
                                                       {stretch_reg[31], stretch_reg}));
            end
            dsf_pkg::MOP_DP:
            begin
                dp_reg <= dsf_pkg::sat32(dsf_pkg::qmul({1'b0, damping}, {quo[31], quo}));
            end
            dsf_pkg::MOP_VALUE:
            begin
                value_reg <= dsf_pkg::sat32(dsf_pkg::sx64(sk_reg) + dsf_pkg::sx64(dp_reg));
            end
            default:
            begin
                m_reg <= m_reg;
            end
        endcase
    end

    assign m              = m_reg;
    assign value          = value_reg;
    assign stat.sqrt_busy = sqrt_busy;
    assign stat.div_busy  = div_busy;

endmodule

// ----- hdl/damped_spring_follower.sv -----
// top level of the damped spring follower: sequencer, configuration and result register
//
// A mass on a damped spring follows the 3D target given by each input transfer. The block
// takes one item at a time: after acceptance it updates the time backlog and makes the
// snap test, then runs substeps while the backlog exceeds dt, where dt comes from the
// step-rate code in steps_reg, and a last check. One substep is set by the square root in
// the merge stage and two divider passes (projected speed and direction in parallel, then
// force over mass in each axis lane). A snap onto the target costs no substeps. A stalled
// result adds its stall time. The finished result sits in an output register, so the next
// item is taken while it waits.
module damped_spring_follower (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] target_x,
    input  logic signed [31:0] target_y,
    input  logic signed [31:0] target_z,
    input  logic [47:0]        time_now,
    input  logic signed [31:0] frame_number,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] pos_x,
    output logic signed [31:0] pos_y,
    output logic signed [31:0] pos_z,
    output logic               restarted
);

    dsf_pkg::state_t state_reg, state_next;

    logic [31:0]        stiffness_reg;
    logic [31:0]        damping_reg;
    logic [31:0]        friction_reg;
    logic [31:0]        rest_length_reg;
    logic [31:0]        mass_reg;
    logic [7:0]         steps_reg;
    logic signed [31:0] zero_frame_reg;
    logic               time_source_reg;

    logic signed [48:0] bl_reg;
    logic [47:0]        last_sys_reg;
    logic [47:0]        last_loc_reg;
    logic [16:0]        dt_reg;
    logic               snap_reg;

    logic signed [31:0] tg_reg [3];
    logic [47:0]        t_reg;
    logic signed [31:0] frame_reg;

    logic               out_valid_reg;
    logic signed [31:0] out_pos_reg [3];
    logic               out_restarted_reg;

    logic [16:0]         dt_tab [256];
    logic signed [50:0]  bl_sum;
    logic signed [48:0]  bl_sat;
    logic [47:0]         last_t;
    logic                snap_now;
    logic                out_load;
    logic [31:0]         mass_eff;
    dsf_pkg::lane_ctl_t  lane_ctl;
    dsf_pkg::merge_ctl_t merge_ctl;
    dsf_pkg::merge_stat_t mstat;
    logic [63:0]         lane_sq [3];
    logic signed [49:0]  lane_dot [3];
    logic signed [31:0]  lane_pos [3];
    logic [2:0]          lane_busy;
    logic [31:0]         m;
    logic signed [31:0]  value;

    // substep length per step-rate code, rounded
    for (genvar g = 0; g < 256; g++)
    begin : g_dt
        localparam int STEPS_EFF = (g == 0) ? dsf_pkg::STEPS_DEFAULT :
                                   ((g > dsf_pkg::STEPS_MAX) ? dsf_pkg::STEPS_MAX : g);
        localparam int DT_VAL = (65536 + STEPS_EFF / 2) / STEPS_EFF;
        assign dt_tab[g] = 17'(DT_VAL);
    end

    assign mass_eff = (mass_reg == 32'd0) ? 32'd1 : mass_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stiffness_reg   <= 32'd81920;
            damping_reg     <= 32'd6554;
            friction_reg    <= 32'd9830;
            rest_length_reg <= 32'd0;
            mass_reg        <= 32'd131072;
            steps_reg       <= 8'd30;
            zero_frame_reg  <= '0;
            time_source_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (dsf_pkg::cfg_index_t'(cfg_index))
                dsf_pkg::CFG_STIFFNESS:   stiffness_reg   <= cfg_data;
                dsf_pkg::CFG_DAMPING:     damping_reg     <= cfg_data;
                dsf_pkg::CFG_FRICTION:    friction_reg    <= cfg_data;
                dsf_pkg::CFG_REST_LENGTH: rest_length_reg <= cfg_data;
                dsf_pkg::CFG_MASS:        mass_reg        <= cfg_data;
                dsf_pkg::CFG_STEPS:       steps_reg       <= cfg_data[7:0];
                dsf_pkg::CFG_ZERO_FRAME:  zero_frame_reg  <= cfg_data;
                dsf_pkg::CFG_TIME_SOURCE: time_source_reg <= cfg_data[0];
                default:                  time_source_reg <= time_source_reg;
            endcase
        end
    end

    // backlog update, snap decision and result-register load condition
    always_comb
    begin
        last_t   = time_source_reg ? last_sys_reg : last_loc_reg;
        bl_sum   = {{2{bl_reg[48]}}, bl_reg} + $signed({3'b0, t_reg})
                   - $signed({3'b0, last_t});
        bl_sat   = (bl_sum > dsf_pkg::BL_MAX) ? dsf_pkg::BL_MAX[48:0] :
                   ((bl_sum < dsf_pkg::BL_MIN) ? dsf_pkg::BL_MIN[48:0] : bl_sum[48:0]);
        snap_now = (bl_reg > dsf_pkg::RESET_LIMIT)
                   || (!time_source_reg && frame_reg == zero_frame_reg);
        out_load = (state_reg == dsf_pkg::ST_OUT) && (!out_valid_reg || !out_stall);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            dsf_pkg::ST_IDLE:      if (in_valid) state_next = dsf_pkg::ST_BACKLOG;
            dsf_pkg::ST_BACKLOG:   state_next = dsf_pkg::ST_DECIDE;
            dsf_pkg::ST_DECIDE:    state_next = snap_now ? dsf_pkg::ST_OUT : dsf_pkg::ST_CHECK;
            dsf_pkg::ST_CHECK:
            begin
                state_next = (bl_reg > $signed({32'b0, dt_reg})) ? dsf_pkg::ST_DIFF
                                                                 : dsf_pkg::ST_OUT;
            end
            dsf_pkg::ST_DIFF:      state_next = dsf_pkg::ST_SQ;
            dsf_pkg::ST_SQ:        state_next = dsf_pkg::ST_DOT;
            dsf_pkg::ST_DOT:       state_next = dsf_pkg::ST_SUM;
            dsf_pkg::ST_SUM:       state_next = dsf_pkg::ST_SQRT;
            dsf_pkg::ST_SQRT:      state_next = dsf_pkg::ST_SQRT_WAIT;
            dsf_pkg::ST_SQRT_WAIT: if (!mstat.sqrt_busy) state_next = dsf_pkg::ST_LEN;
            dsf_pkg::ST_LEN:       state_next = dsf_pkg::ST_DIV1;
            dsf_pkg::ST_DIV1:      state_next = dsf_pkg::ST_DIV1_WAIT;
            dsf_pkg::ST_DIV1_WAIT: if (!mstat.div_busy) state_next = dsf_pkg::ST_SK;
            dsf_pkg::ST_SK:        state_next = dsf_pkg::ST_DP;
            dsf_pkg::ST_DP:        state_next = dsf_pkg::ST_VALUE;
            dsf_pkg::ST_VALUE:     state_next = dsf_pkg::ST_ACC;
            dsf_pkg::ST_ACC:       state_next = dsf_pkg::ST_FDIV;
            dsf_pkg::ST_FDIV:      state_next = dsf_pkg::ST_FR;
            dsf_pkg::ST_FR:        state_next = dsf_pkg::ST_FDIV_WAIT;
            dsf_pkg::ST_FDIV_WAIT: if (!lane_busy[0]) state_next = dsf_pkg::ST_VEL;
            dsf_pkg::ST_VEL:       state_next = dsf_pkg::ST_PMUL;
            dsf_pkg::ST_PMUL:      state_next = dsf_pkg::ST_POS;
            dsf_pkg::ST_POS:       state_next = dsf_pkg::ST_CHECK;
            dsf_pkg::ST_OUT:       if (out_load) state_next = dsf_pkg::ST_IDLE;
            default:               state_next = dsf_pkg::ST_IDLE;
        endcase
    end

    // lane and merge commands
    always_comb
    begin
        lane_ctl.op  = dsf_pkg::LOP_IDLE;
        merge_ctl.op = dsf_pkg::MOP_IDLE;
        unique case (state_reg)
            dsf_pkg::ST_DECIDE: if (snap_now) lane_ctl.op = dsf_pkg::LOP_SNAP;
            dsf_pkg::ST_DIFF:   lane_ctl.op = dsf_pkg::LOP_DIFF;
            dsf_pkg::ST_SQ:     lane_ctl.op = dsf_pkg::LOP_SQ;
            dsf_pkg::ST_DOT:    lane_ctl.op = dsf_pkg::LOP_DOT;
            dsf_pkg::ST_SUM:    merge_ctl.op = dsf_pkg::MOP_SUM;
            dsf_pkg::ST_SQRT:   merge_ctl.op = dsf_pkg::MOP_SQRT;
            dsf_pkg::ST_LEN:    merge_ctl.op = dsf_pkg::MOP_LEN;
            dsf_pkg::ST_DIV1:
            begin
                merge_ctl.op = dsf_pkg::MOP_PROJ_DIV;
                lane_ctl.op  = dsf_pkg::LOP_DIR_DIV;
            end
            dsf_pkg::ST_SK:     merge_ctl.op = dsf_pkg::MOP_SK;
            dsf_pkg::ST_DP:     merge_ctl.op = dsf_pkg::MOP_DP;
            dsf_pkg::ST_VALUE:  merge_ctl.op = dsf_pkg::MOP_VALUE;
            dsf_pkg::ST_ACC:    lane_ctl.op = dsf_pkg::LOP_ACC;
            dsf_pkg::ST_FDIV:   lane_ctl.op = dsf_pkg::LOP_F_DIV;
            dsf_pkg::ST_FR:     lane_ctl.op = dsf_pkg::LOP_FR;
            dsf_pkg::ST_VEL:    lane_ctl.op = dsf_pkg::LOP_VEL;
            dsf_pkg::ST_PMUL:   lane_ctl.op = dsf_pkg::LOP_PMUL;
            dsf_pkg::ST_POS:    lane_ctl.op = dsf_pkg::LOP_POS;
            default:            lane_ctl.op = dsf_pkg::LOP_IDLE;
        endcase
    end

    // control state, backlog, time history and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dsf_pkg::ST_IDLE;
            bl_reg        <= '0;
            last_sys_reg  <= '0;
            last_loc_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == dsf_pkg::ST_BACKLOG)
            begin
                bl_reg <= bl_sat;
                if (time_source_reg)
                begin
                    last_sys_reg <= t_reg;
                end
                else
                begin
                    last_loc_reg <= t_reg;
                end
            end
            else if (state_reg == dsf_pkg::ST_DECIDE && snap_now)
            begin
                bl_reg <= '0;
            end
            else if (state_reg == dsf_pkg::ST_POS)
            begin
                bl_reg <= bl_reg - $signed({32'b0, dt_reg});
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // item capture, substep length and snap flag, and result register
    always_ff @(posedge clk)
    begin
        if (state_reg == dsf_pkg::ST_IDLE && in_valid)
        begin
            tg_reg[0] <= target_x;
            tg_reg[1] <= target_y;
            tg_reg[2] <= target_z;
            t_reg     <= time_now;
            frame_reg <= frame_number;
        end
        if (state_reg == dsf_pkg::ST_DECIDE)
        begin
            dt_reg   <= dt_tab[steps_reg];
            snap_reg <= snap_now;
        end
        if (out_load)
        begin
            out_pos_reg[0]    <= lane_pos[0];
            out_pos_reg[1]    <= lane_pos[1];
            out_pos_reg[2]    <= lane_pos[2];
            out_restarted_reg <= snap_reg;
        end
    end

    // one lane per axis
    for (genvar i = 0; i < 3; i++)
    begin : g_lane
        dsf_lane u_lane (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (lane_ctl),
            .tg       (tg_reg[i]),
            .m        (m),
            .value    (value),
            .friction (friction_reg),
            .mass_eff (mass_eff),
            .dt       (dt_reg),
            .sq       (lane_sq[i]),
            .dotp     (lane_dot[i]),
            .pos      (lane_pos[i]),
            .busy     (lane_busy[i])
        );
    end

    dsf_merge u_merge (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (merge_ctl),
        .sq          (lane_sq),
        .dotp        (lane_dot),
        .stiffness   (stiffness_reg),
        .damping     (damping_reg),
        .rest_length (rest_length_reg),
        .m           (m),
        .value       (value),
        .stat        (mstat)
    );

    assign in_stall  = (state_reg != dsf_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;
    assign pos_x     = out_pos_reg[0];
    assign pos_y     = out_pos_reg[1];
    assign pos_z     = out_pos_reg[2];
    assign restarted = out_restarted_reg;

    // an accepted transfer holds off the next one
    a_accept_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input accepted twice in a row");

    // no arithmetic unit (merge square root and divider, lane 0 divider) is left running between items
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == dsf_pkg::ST_IDLE |-> !mstat.sqrt_busy && !mstat.div_busy && !lane_busy[0])
        else $error("arithmetic unit busy while idle");

    // substeps leave at most one step of backlog behind
    a_backlog_drained: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == dsf_pkg::ST_OUT |-> bl_reg <= $signed({32'b0, dt_reg}))
        else $error("backlog left above one substep");

endmodule
